[sv/ld8b_pkg.sv]
// ld8b_pkg: widths, code tables and precomputed nearest-entry lookups for the
// 8b10b-style line decoder. No dependencies; imported by every module of the block.
package ld8b_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FRAME_W    = 16;
  localparam int CMP_W      = (COUNT_BITS > FRAME_W) ? COUNT_BITS : FRAME_W;
  localparam int WORD_BITS  = 10;
  localparam int HIGH_LEN   = 4;
  localparam int LOW_LEN    = 6;
  localparam int HIGH_ENT   = 8;
  localparam int LOW_ENT    = 32;
  localparam int HIGH_IDX_W = 3;
  localparam int LOW_IDX_W  = 5;
  localparam int ONES_W     = 4;
  localparam logic [ONES_W-1:0] BALANCED_ONES = 4'd5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  typedef logic [HIGH_LEN-1:0] high_row_t;
  typedef logic [LOW_LEN-1:0]  low_row_t;
  typedef high_row_t high_tab_t [HIGH_ENT];
  typedef low_row_t  low_tab_t  [LOW_ENT];
  typedef logic [HIGH_IDX_W-1:0] high_lut_t [2*(1<<HIGH_LEN)];
  typedef logic [LOW_IDX_W-1:0]  low_lut_t  [2*(1<<LOW_LEN)];

  // rows written in received order, left to right: element j is bit LEN-1-j
  localparam high_tab_t HIGH_NEG = '{
    4'b0010, 4'b1001, 4'b1010, 4'b1100, 4'b0100, 4'b0101, 4'b0110, 4'b1000};
  localparam high_tab_t HIGH_POS = '{
    4'b1101, 4'b1001, 4'b1010, 4'b0011, 4'b1011, 4'b0101, 4'b0110, 4'b0111};
  localparam low_tab_t LOW_NEG = '{
    6'b111001, 6'b101110, 6'b101101, 6'b100011, 6'b101011, 6'b100101, 6'b100110, 6'b000111,
    6'b100111, 6'b101001, 6'b101010, 6'b001011, 6'b101100, 6'b001101, 6'b001110, 6'b111010,
    6'b110110, 6'b110001, 6'b110010, 6'b010011, 6'b110100, 6'b010101, 6'b010110, 6'b010111,
    6'b110011, 6'b011001, 6'b011010, 6'b011011, 6'b011100, 6'b011101, 6'b011110, 6'b110101};
  localparam low_tab_t LOW_POS = '{
    6'b000110, 6'b010001, 6'b010010, 6'b100011, 6'b010100, 6'b100101, 6'b100110, 6'b111000,
    6'b011000, 6'b101001, 6'b101010, 6'b001011, 6'b101100, 6'b001101, 6'b001110, 6'b000101,
    6'b001001, 6'b110001, 6'b110010, 6'b010011, 6'b110100, 6'b010101, 6'b010110, 6'b101000,
    6'b001100, 6'b011001, 6'b011010, 6'b100100, 6'b011100, 6'b100010, 6'b100001, 6'b001010};

  // evaluated at elaboration only: nearest entry by hamming distance, lowest index on ties
  function automatic high_lut_t build_high_lut();
    high_lut_t lut;
    int        best;
    int        best_d;
    int        d;
    high_row_t row;
    for (int p = 0; p < 2; p++) begin
      for (int v = 0; v < (1 << HIGH_LEN); v++) begin
        best   = 0;
        best_d = HIGH_LEN + 1;
        for (int i = 0; i < HIGH_ENT; i++) begin
          row = (p != 0) ? HIGH_POS[i] : HIGH_NEG[i];
          d   = 0;
          for (int j = 0; j < HIGH_LEN; j++) begin
            if (((v >> j) & 1) != int'(row[HIGH_LEN-1-j])) d++;
          end
          if (d < best_d) begin
            best_d = d;
            best   = i;
          end
        end
        lut[p*(1<<HIGH_LEN)+v] = HIGH_IDX_W'(best);
      end
    end
    return lut;
  endfunction

  function automatic low_lut_t build_low_lut();
    low_lut_t lut;
    int       best;
    int       best_d;
    int       d;
    low_row_t row;
    for (int p = 0; p < 2; p++) begin
      for (int v = 0; v < (1 << LOW_LEN); v++) begin
        best   = 0;
        best_d = LOW_LEN + 1;
        for (int i = 0; i < LOW_ENT; i++) begin
          row = (p != 0) ? LOW_POS[i] : LOW_NEG[i];
          d   = 0;
          for (int j = 0; j < LOW_LEN; j++) begin
            if (((v >> j) & 1) != int'(row[LOW_LEN-1-j])) d++;
          end
          if (d < best_d) begin
            best_d = d;
            best   = i;
          end
        end
        lut[p*(1<<LOW_LEN)+v] = LOW_IDX_W'(best);
      end
    end
    return lut;
  endfunction

  localparam high_lut_t HIGH_LUT = build_high_lut();
  localparam low_lut_t  LOW_LUT  = build_low_lut();

  typedef struct packed {
    logic [HIGH_IDX_W-1:0] value_high3;
    logic [LOW_IDX_W-1:0]  value_low5;
    logic                  flip;
  } match_t;

endpackage

[sv/ld8b_match.sv]
// ld8b_match: table match of one code word under a given disparity, plus the
// disparity flip from the ones count. Depends on ld8b_pkg.
module ld8b_match (
  input  logic [ld8b_pkg::WORD_BITS-1:0] code_word,
  input  logic                           disparity,
  output ld8b_pkg::match_t               res
);
  import ld8b_pkg::*;

  logic [ONES_W-1:0] ones;

  always_comb begin
    ones = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      ones = ones + ONES_W'(code_word[k]);
    end
  end

  always_comb begin
    res.value_high3 = HIGH_LUT[{disparity, code_word[HIGH_LEN-1:0]}];
    res.value_low5  = LOW_LUT[{disparity, code_word[WORD_BITS-1:HIGH_LEN]}];
    res.flip        = (ones != BALANCED_ONES);
  end

endmodule

[sv/line_decoder_8b10b.sv]
// line_decoder_8b10b: top level of the 8b10b-style line decoder, with input
// register, disparity and frame counter state and result register. Depends on
// ld8b_pkg and ld8b_match.
//
// One 10-bit code word per request in, one result (3-bit and 5-bit table
// indices) per request out. A word passes through the input register and then
// lands in the result register, and the block sustains one word per cycle while
// the result side is not stalled; the feedback is the one-bit running disparity
// and the frame counter, both updated as each word leaves the input register.
// Matching is a lookup in precomputed nearest-entry tables. frame_words is
// written over the cfg channel, which is ready whenever the input register is
// empty, so a write never overtakes a word already taken; at each frame wrap the
// disparity returns to negative.
module line_decoder_8b10b (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ld8b_pkg::IN_DATA_W-1:0]  in_tdata,   // [9:0] code_word
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ld8b_pkg::OUT_DATA_W-1:0] out_tdata,  // [2:0] value_high3, [7:3] value_low5
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ld8b_pkg::FRAME_W-1:0]    cfg_data    // frame_words
);
  import ld8b_pkg::*;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [WORD_BITS-1:0]  s1_word_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [HIGH_IDX_W-1:0] out_high_r;
  logic [LOW_IDX_W-1:0]  out_low_r;
  logic                  disp_r, disp_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [FRAME_W-1:0]    frame_r;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  wrap;
  logic                  s1_adv;
  logic                  in_acc;
  match_t                m;

  ld8b_match u_match (
    .code_word (s1_word_r),
    .disparity (disp_r),
    .res       (m)
  );

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = !s1_valid_r;

  always_comb begin
    count_inc = count_r + COUNT_BITS'(1);
    wrap      = (count_inc == '0) || (CMP_W'(count_inc) >= CMP_W'(frame_r));
    count_nxt = count_r;
    disp_nxt  = disp_r;
    if (s1_adv) begin
      count_nxt = wrap ? '0 : count_inc;
      disp_nxt  = wrap ? 1'b0 : (disp_r ^ m.flip);
    end
    s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : ((out_valid_r && out_tready) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      disp_r      <= 1'b0;
      count_r     <= '0;
      frame_r     <= FRAME_W'(1);
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      disp_r      <= disp_nxt;
      count_r     <= count_nxt;
      if (cfg_valid && cfg_ready) frame_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_word_r <= in_tdata[WORD_BITS-1:0];
    if (s1_adv) begin
      out_high_r <= m.value_high3;
      out_low_r  <= m.value_low5;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_low_r, out_high_r};

endmodule

[sv/ld8b_checker.sv]
// ld8b_checker: port-level assertions for line_decoder_8b10b, bound to the top
// level. Depends on ld8b_pkg.
module ld8b_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ld8b_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ld8b_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // input only backs up when the result side is full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with room downstream");

  // every accepted request passes the input register and then shows up at the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("accepted request did not reach the output");

endmodule

bind line_decoder_8b10b ld8b_checker u_ld8b_checker (.*);
